/* sv/bpfa_pkg.sv */
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types, codes and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int NUM_PAGES_DEF = 65536;
  localparam int WORD_BITS     = 64;
  localparam int PAGE_W        = 16;
  localparam int LIMIT_W       = 17;
  localparam int CNT_W         = LIMIT_W - 6;

  localparam logic [PAGE_W-1:0]  BOOT_FLOOR_PAGE    = 16'd512;
  localparam logic [LIMIT_W-1:0] FIRST_USABLE_RESET = 17'd512;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MAKE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  localparam logic REG_FIRST_USABLE = 1'b0;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MODIFY
  } state_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [5:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* sv/bitmap_page_frame_allocator.sv */
// Operation: allocate scans the 64-page map words in order, at most
//   ceil(tracked_limit / 64) of them; free and make-available read the page's
//   word and rewrite it if the page is used; a rejected or unknown request answers from idle.
// Throughput: one transaction at a time; the next start is taken once busy is low.
// Reset: a clearing pass writes all-ones into every map word, NUM_PAGES / 64
//   of them (1024 by default), with busy high; results are never stalled.
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a one-bit-per-page used map in block RAM.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode,
  input  logic [PAGE_W-1:0]   page_index,
  output logic                done,
  output logic [1:0]          status,
  output logic [PAGE_W-1:0]   page_out,
  output logic [LIMIT_W-1:0]  free_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // The used map: one bit per page, 64 pages per word, one read and one
  // write port, registered read data.
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic                 rd_en;
  logic [WORD_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [WORD_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  state_t state, state_next;

  logic [WORD_W-1:0]  clr_addr, clr_addr_next;
  logic [CNT_W-1:0]   chk_word, chk_word_next;
  logic [1:0]         op_q;
  logic [PAGE_W-1:0]  page_q;
  logic [LIMIT_W-1:0] tracked_limit, tracked_limit_next;
  logic [LIMIT_W-1:0] free_total, free_total_next;
  logic [LIMIT_W-1:0] first_usable;
  logic               done_next;
  logic [1:0]         status_next;
  logic [PAGE_W-1:0]  page_out_next;

  logic                 accept;
  logic [LIMIT_W:0]     limit_round;
  logic [CNT_W-1:0]     words;
  logic [LIMIT_W-1:0]   page_ext;
  logic                 reserved;
  logic [LIMIT_W-1:0]   base;
  logic [LIMIT_W-1:0]   rem;
  logic [WORD_BITS-1:0] avail;
  logic [5:0]           hit_bit;
  logic                 page_used;
  logic                 cfg_wr;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FIRST_USABLE) ? {15'b0, first_usable} : 32'b0;

  assign free_count = free_total;

  // Number of map words that hold tracked pages.
  assign limit_round = {1'b0, tracked_limit} + (LIMIT_W+1)'(WORD_BITS - 1);
  assign words       = CNT_W'(limit_round >> 6);

  // Make-available refuses the boot area, pages below the configured floor,
  // and pages past the end of the map.
  assign page_ext = {1'b0, page_index};
  assign reserved = (page_index < BOOT_FLOOR_PAGE) || (page_ext < first_usable) ||
                    (32'(page_index) >= NUM_PAGES);

  // The word under inspection is masked to the pages below the limit.
  assign base = {chk_word, 6'b0};
  assign rem  = tracked_limit - base;
  always_comb begin
    avail = ~rdata;
    if (rem < LIMIT_W'(WORD_BITS)) begin
      avail = avail & ~({WORD_BITS{1'b1}} << rem[5:0]);
    end
  end
  assign hit_bit   = lowest_set(avail);
  assign page_used = rdata[page_q[5:0]];

  // Map RAM.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable <= FIRST_USABLE_RESET;
    end else if (cfg_wr && paddr[2] == REG_FIRST_USABLE) begin
      first_usable <= pwdata[LIMIT_W-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      chk_word      <= '0;
      tracked_limit <= '0;
      free_total    <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      chk_word      <= chk_word_next;
      tracked_limit <= tracked_limit_next;
      free_total    <= free_total_next;
      done          <= done_next;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode;
      page_q <= page_index;
    end
    status   <= status_next;
    page_out <= page_out_next;
  end

  always_comb begin
    state_next         = state;
    clr_addr_next      = clr_addr;
    chk_word_next      = chk_word;
    tracked_limit_next = tracked_limit;
    free_total_next    = free_total;
    done_next          = 1'b0;
    status_next        = status;
    page_out_next      = page_out;
    rd_en              = 1'b0;
    rd_addr            = '0;
    wr_en              = 1'b0;
    wr_addr            = '0;
    wr_data            = '0;

    unique case (state)
      S_CLEAR: begin
        // Every page starts out used.
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = {WORD_BITS{1'b1}};
        if (clr_addr == WORD_W'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          page_out_next = '0;
          unique case (opcode)
            OP_ALLOC: begin
              if (words == '0) begin
                done_next   = 1'b1;
                status_next = ST_OOM;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = '0;
                chk_word_next = '0;
                state_next    = S_SCAN;
              end
            end
            OP_FREE: begin
              if (page_ext >= tracked_limit) begin
                done_next   = 1'b1;
                status_next = ST_IGNORED;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = WORD_W'(page_index >> 6);
                state_next = S_MODIFY;
              end
            end
            OP_MAKE: begin
              if (reserved) begin
                done_next   = 1'b1;
                status_next = ST_RESERVED;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = WORD_W'(page_index >> 6);
                state_next = S_MODIFY;
              end
            end
            default: begin
              // An unknown opcode changes nothing.
              done_next   = 1'b1;
              status_next = ST_IGNORED;
            end
          endcase
        end
      end

      S_SCAN: begin
        // rdata holds map word chk_word; the next word is fetched each cycle
        // until a free page turns up or the tracked words run out.
        if (avail != '0) begin
          wr_en           = 1'b1;
          wr_addr         = WORD_W'(chk_word);
          wr_data         = rdata | (WORD_BITS'(1) << hit_bit);
          free_total_next = free_total - 1'b1;
          done_next       = 1'b1;
          status_next     = ST_OK;
          page_out_next   = PAGE_W'(base | LIMIT_W'(hit_bit));
          state_next      = S_IDLE;
        end else if (chk_word + 1'b1 == words) begin
          done_next     = 1'b1;
          status_next   = ST_OOM;
          page_out_next = '0;
          state_next    = S_IDLE;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = WORD_W'(chk_word + 1'b1);
          chk_word_next = chk_word + 1'b1;
        end
      end

      S_MODIFY: begin
        // Read-modify-write of the page's word; only a used page changes.
        done_next     = 1'b1;
        page_out_next = '0;
        state_next    = S_IDLE;
        if (page_used) begin
          wr_en           = 1'b1;
          wr_addr         = WORD_W'(page_q >> 6);
          wr_data         = rdata & ~(WORD_BITS'(1) << page_q[5:0]);
          free_total_next = free_total + 1'b1;
          status_next     = ST_OK;
          if (op_q == OP_MAKE && {1'b0, page_q} >= tracked_limit) begin
            tracked_limit_next = {1'b0, page_q} + 1'b1;
          end
        end else begin
          status_next = (op_q == OP_FREE) ? ST_IGNORED : ST_OK;
        end
      end
    endcase
  end

  // Free pages all lie below the tracked limit.
  assert property (@(posedge clk) disable iff (rst) free_total <= tracked_limit)
    else $error("free count exceeds tracked limit");

  // A successful allocation hands out a tracked page.
  assert property (@(posedge clk) disable iff (rst)
      done && status == ST_OK && page_out != '0 |-> {1'b0, page_out} < tracked_limit)
    else $error("allocated page outside tracked range");

  // The scan never looks past the tracked words.
  assert property (@(posedge clk) disable iff (rst) state == S_SCAN |-> chk_word < words)
    else $error("scan ran past the tracked words");

  // No result comes out of the clearing pass.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) != S_CLEAR)
    else $error("result during clearing pass");

endmodule
